// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define BWTS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent that must hold in the cycle after the antecedent
`define BWTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/bwts_pkg.sv =====
// shared types and constants of the bilinear wrap texture sampler
// no dependencies
`default_nettype none
package bwts_pkg;

	localparam int TexelDepth   = 65536;
	localparam int PaletteDepth = 256;
	localparam int TexelAw      = $clog2(TexelDepth);
	localparam int PaletteAw    = $clog2(PaletteDepth);
	localparam int RgbW         = 24;
	localparam int SizeW        = 9;
	localparam logic [SizeW-1:0] SizeMax = 9'd256;

	typedef enum logic [1:0] {
		CMD_WR_TEXEL = 2'd0,
		CMD_WR_PAL   = 2'd1,
		CMD_SAMPLE   = 2'd2,
		CMD_NONE     = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_TEX_WIDTH  = 3'd0,
		REG_TEX_HEIGHT = 3'd1,
		REG_PALETTED   = 3'd2,
		REG_OFFSET_X   = 3'd3,
		REG_OFFSET_Y   = 3'd4,
		REG_SCALE_X    = 3'd5,
		REG_SCALE_Y    = 3'd6,
		REG_UNUSED     = 3'd7
	} reg_idx_t;

	// wrapped texel coordinate and 16 bit blend fraction of one axis
	typedef struct packed {
		logic [7:0]  coord;
		logic [15:0] frac;
	} coord_t;

endpackage
`default_nettype wire

// ===== sv/bwts_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module bwts_ram #(
	parameter int W     = 24,
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);

	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== sv/bwts_coord.sv =====
// three stage coordinate unit of one axis: offset, scale, size split
// depends on bwts_pkg
`default_nettype none
module bwts_coord (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic [31:0]                 pos,
	input  wire logic [31:0]                 off,
	input  wire logic [31:0]                 scl,
	input  wire logic [bwts_pkg::SizeW-1:0]  size,
	output bwts_pkg::coord_t                 loc
);

	// only the fraction of the scaled position decides the wrapped texel,
	// so low 32 bits of the difference and of the product are enough
	logic [31:0] diff_s1;
	logic [15:0] sfrac_s2;
	logic [31:0] prod;
	logic [23:0] split;

	assign prod  = diff_s1 * scl;
	assign split = {8'd0, sfrac_s2} * {15'd0, size};

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1   <= pos - off;
			sfrac_s2  <= prod[31:16];
			loc.coord <= split[23:16];
			loc.frac  <= split[15:0];
		end
	end

endmodule
`default_nettype wire

// ===== sv/bwts_lerp.sv =====
// two stage bilinear blend of one color channel
// no dependencies
`default_nettype none
module bwts_lerp (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [7:0]  p00,
	input  wire logic [7:0]  p01,
	input  wire logic [7:0]  p10,
	input  wire logic [7:0]  p11,
	input  wire logic [15:0] fx,
	input  wire logic [15:0] fy,
	output logic      [15:0] res
);

	logic [16:0] fy_inv;
	logic [16:0] fx_inv;
	logic [23:0] left_s1;
	logic [23:0] right_s1;
	logic [15:0] fx_s1;
	logic [40:0] mix;

	assign fy_inv = 17'h10000 - {1'b0, fy};
	assign fx_inv = 17'h10000 - {1'b0, fx_s1};
	assign mix    = {17'd0, left_s1} * {24'd0, fx_inv}
		+ {17'd0, right_s1} * {25'd0, fx_s1};

	always_ff @(posedge clk) begin
		if (en) begin
			left_s1  <= {16'd0, p00} * {7'd0, fy_inv} + {16'd0, p01} * {8'd0, fy};
			right_s1 <= {16'd0, p10} * {7'd0, fy_inv} + {16'd0, p11} * {8'd0, fy};
			fx_s1    <= fx;
			res      <= mix[39:24];
		end
	end

endmodule
`default_nettype wire

// ===== sv/bilinear_wrap_texture_sampler.sv =====
// top level of the bilinear wrap texture sampler
// depends on bwts_pkg, bwts_ram, bwts_coord, bwts_lerp
//
// Takes one command per cycle: texel write, palette write or sample. A sample gives
// one RGB result in unsigned 8.8 after three coordinate stages, texel read, palette
// read and two blend stages; writes give no result and unused command code 3 is
// dropped at the input. The whole pipeline advances together: it stalls only while
// a result sits in the output register and the sink holds m_tready low. Four texel
// reads per sample are served by four copies of the texel memory and four of the
// palette, all written together; texel writes land at the texel read stage and
// palette writes at the palette read stage, so every command sees memory exactly as
// the commands before it left it. Memories are not cleared: reading a never written
// entry gives undefined data. Configuration (cfg_index = register number) may only
// be written while the block is idle.
`default_nettype none
module bilinear_wrap_texture_sampler (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// stream in
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// texel_address, palette_index, red_in, green_in, blue_in, pos_x, pos_y
	input  wire logic [111:0] s_tdata,
	// command
	input  wire logic [1:0]   s_tuser,
	// stream out
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// red_out, green_out, blue_out
	output logic      [47:0]  m_tdata,
	// configuration writes
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);

	localparam int Aw = bwts_pkg::TexelAw;
	localparam int Pw = bwts_pkg::PaletteAw;
	localparam int Cw = bwts_pkg::RgbW;

	// configuration registers
	logic [bwts_pkg::SizeW-1:0] width_q;
	logic [bwts_pkg::SizeW-1:0] height_q;
	logic                       paletted_q;
	logic [31:0]                offset_x_q;
	logic [31:0]                offset_y_q;
	logic [31:0]                scale_x_q;
	logic [31:0]                scale_y_q;
	logic [bwts_pkg::SizeW-1:0] size_eff;

	// pipeline control
	logic              adv;
	logic              in_xfer;
	bwts_pkg::cmd_t    cmd_in;
	logic              valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	bwts_pkg::cmd_t    cmd_s1, cmd_s2, cmd_s3, cmd_s4, cmd_s5;

	// write payload riding along
	logic [Aw-1:0]     waddr_s1, waddr_s2, waddr_s3;
	logic [Cw-1:0]     wtex_s1, wtex_s2, wtex_s3;
	logic [Pw-1:0]     pidx_s1, pidx_s2, pidx_s3, pidx_s4;
	logic [Cw-1:0]     rgb_s1, rgb_s2, rgb_s3, rgb_s4;

	// sample path
	bwts_pkg::coord_t  loc_x_s3, loc_y_s3;
	logic [7:0]        x1, y1;
	logic [Aw-1:0]     raddr [4];
	logic [15:0]       fx_s4, fy_s4, fx_s5, fy_s5;
	logic [Cw-1:0]     tex_s4 [4];
	logic [Cw-1:0]     tex_s5 [4];
	logic [Cw-1:0]     pal_s5 [4];
	logic [Cw-1:0]     pix [4];
	logic              paletted_s5;

	// output stage holds; otherwise everything moves
	assign adv       = !valid_s7 || m_tready;
	assign s_tready  = adv;
	assign cfg_ready = 1'b1;
	assign in_xfer   = s_tvalid && s_tready;
	assign cmd_in    = bwts_pkg::cmd_t'(s_tuser);

	// size 0 acts as 1, above 256 as 256
	always_comb begin
		size_eff = cfg_data[bwts_pkg::SizeW-1:0];
		if (size_eff == '0) begin
			size_eff = bwts_pkg::SizeW'(1);
		end else if (size_eff > bwts_pkg::SizeMax) begin
			size_eff = bwts_pkg::SizeMax;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= bwts_pkg::SizeMax;
			height_q   <= bwts_pkg::SizeMax;
			paletted_q <= 1'b0;
			offset_x_q <= '0;
			offset_y_q <= '0;
			scale_x_q  <= 32'h0001_0000;
			scale_y_q  <= 32'h0001_0000;
		end else if (cfg_valid && cfg_ready) begin
			case (bwts_pkg::reg_idx_t'(cfg_index))
				bwts_pkg::REG_TEX_WIDTH:  width_q    <= size_eff;
				bwts_pkg::REG_TEX_HEIGHT: height_q   <= size_eff;
				bwts_pkg::REG_PALETTED:   paletted_q <= cfg_data[0];
				bwts_pkg::REG_OFFSET_X:   offset_x_q <= cfg_data;
				bwts_pkg::REG_OFFSET_Y:   offset_y_q <= cfg_data;
				bwts_pkg::REG_SCALE_X:    scale_x_q  <= cfg_data;
				bwts_pkg::REG_SCALE_Y:    scale_y_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// valid bits; code 3 never enters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_xfer && (cmd_in != bwts_pkg::CMD_NONE);
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			// from here on only samples travel
			valid_s6 <= valid_s5 && (cmd_s5 == bwts_pkg::CMD_SAMPLE);
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1   <= cmd_in;
			waddr_s1 <= s_tdata[15:0];
			pidx_s1  <= s_tdata[23:16];
			rgb_s1   <= {s_tdata[31:24], s_tdata[39:32], s_tdata[47:40]};
			// paletted texels store the index
			wtex_s1  <= paletted_q ? {16'd0, s_tdata[23:16]}
				: {s_tdata[31:24], s_tdata[39:32], s_tdata[47:40]};
			cmd_s2   <= cmd_s1;
			waddr_s2 <= waddr_s1;
			wtex_s2  <= wtex_s1;
			pidx_s2  <= pidx_s1;
			rgb_s2   <= rgb_s1;
			cmd_s3   <= cmd_s2;
			waddr_s3 <= waddr_s2;
			wtex_s3  <= wtex_s2;
			pidx_s3  <= pidx_s2;
			rgb_s3   <= rgb_s2;
			cmd_s4   <= cmd_s3;
			pidx_s4  <= pidx_s3;
			rgb_s4   <= rgb_s3;
			fx_s4    <= loc_x_s3.frac;
			fy_s4    <= loc_y_s3.frac;
			cmd_s5   <= cmd_s4;
			fx_s5    <= fx_s4;
			fy_s5    <= fy_s4;
			tex_s5   <= tex_s4;
			paletted_s5 <= paletted_q;
		end
	end

	bwts_coord u_coord_x (
		.clk  (clk),
		.en   (adv),
		.pos  (s_tdata[79:48]),
		.off  (offset_x_q),
		.scl  (scale_x_q),
		.size (width_q),
		.loc  (loc_x_s3)
	);

	bwts_coord u_coord_y (
		.clk  (clk),
		.en   (adv),
		.pos  (s_tdata[111:80]),
		.off  (offset_y_q),
		.scl  (scale_y_q),
		.size (height_q),
		.loc  (loc_y_s3)
	);

	// neighbor wrap and row-major addresses: 00, 01 (next row), 10 (next column), 11
	always_comb begin
		x1 = ({1'b0, loc_x_s3.coord} + 9'd1 == width_q) ? 8'd0 : loc_x_s3.coord + 8'd1;
		y1 = ({1'b0, loc_y_s3.coord} + 9'd1 == height_q) ? 8'd0 : loc_y_s3.coord + 8'd1;
		raddr[0] = Aw'({9'd0, loc_y_s3.coord} * {8'd0, width_q} + {9'd0, loc_x_s3.coord});
		raddr[1] = Aw'({9'd0, y1} * {8'd0, width_q} + {9'd0, loc_x_s3.coord});
		raddr[2] = Aw'({9'd0, loc_y_s3.coord} * {8'd0, width_q} + {9'd0, x1});
		raddr[3] = Aw'({9'd0, y1} * {8'd0, width_q} + {9'd0, x1});
	end

	for (genvar i = 0; i < 4; i++) begin : g_mem
		bwts_ram #(
			.W     (Cw),
			.DEPTH (bwts_pkg::TexelDepth)
		) u_texel (
			.clk   (clk),
			.we    (adv && valid_s3 && (cmd_s3 == bwts_pkg::CMD_WR_TEXEL)),
			.waddr (waddr_s3),
			.wdata (wtex_s3),
			.re    (adv),
			.raddr (raddr[i]),
			.rdata (tex_s4[i])
		);

		bwts_ram #(
			.W     (Cw),
			.DEPTH (bwts_pkg::PaletteDepth)
		) u_palette (
			.clk   (clk),
			.we    (adv && valid_s4 && (cmd_s4 == bwts_pkg::CMD_WR_PAL)),
			.waddr (pidx_s4),
			.wdata (rgb_s4),
			.re    (adv),
			.raddr (tex_s4[i][Pw-1:0]),
			.rdata (pal_s5[i])
		);

		assign pix[i] = paletted_s5 ? pal_s5[i] : tex_s5[i];
	end

	// channel c: 0 red (bits 23:16), 1 green, 2 blue
	for (genvar c = 0; c < 3; c++) begin : g_chan
		bwts_lerp u_lerp (
			.clk (clk),
			.en  (adv),
			.p00 (pix[0][23-8*c -: 8]),
			.p01 (pix[1][23-8*c -: 8]),
			.p10 (pix[2][23-8*c -: 8]),
			.p11 (pix[3][23-8*c -: 8]),
			.fx  (fx_s5),
			.fy  (fy_s5),
			.res (m_tdata[16*c +: 16])
		);
	end

	assign m_tvalid = valid_s7;

endmodule
`default_nettype wire

// ===== sv/bwts_checker.sv =====
// port level checks of the texture sampler, bound to the top level
// depends on assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module bwts_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata,
	input wire logic        cfg_ready
);

	logic range_ok;

	// every channel at most 255.0 in 8.8
	assign range_ok = (m_tdata[15:0] <= 16'd65280) && (m_tdata[31:16] <= 16'd65280)
		&& (m_tdata[47:32] <= 16'd65280);

	`BWTS_ASSERT(a_cfg_ready, clk, arst_n, cfg_ready, "config port not ready")
	`BWTS_ASSERT(a_ready_when_empty, clk, arst_n, !m_tvalid |-> s_tready, "empty stall")
	`BWTS_ASSERT(a_range, clk, arst_n, !m_tvalid || range_ok, "channel out of range")
	`BWTS_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "held result changed")

endmodule

bind bilinear_wrap_texture_sampler bwts_checker u_bwts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.cfg_ready (cfg_ready)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
// testbench of the bilinear wrap texture sampler: directed and random command streams
// depends on bwts_pkg and bilinear_wrap_texture_sampler; predicts every sample result
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
	} rgb88_t;

	localparam int CycleLimit = 1000000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [111:0] s_tdata = '0;
	logic [1:0]   s_tuser = bwts_pkg::CMD_NONE;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [47:0]  m_tdata;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [2:0]   cfg_index = bwts_pkg::REG_UNUSED;
	logic [31:0]  cfg_data = '0;

	// predictor state: shadow memories and registers
	logic [23:0] texel_shadow [bwts_pkg::TexelDepth];
	logic [23:0] palette_shadow [bwts_pkg::PaletteDepth];
	logic [8:0]  width_reg, height_reg;
	logic        paletted_reg;
	longint      off_x, off_y, scl_x, scl_y;

	rgb88_t expected_rgb [$];
	int     mismatches = 0;
	longint cycle_count = 0;
	bit     random_gaps = 1'b0;
	int     burst_left = 0;
	// receiver behavior: 0 always ready, 1 random stalls
	int     stall_mode = 0;
	int     hold_request = 0;
	int     hold_left = 0;

	bilinear_wrap_texture_sampler i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// ---------------- predictor ----------------
	function automatic int clamp_size(logic [8:0] v);
		if (v == 0) return 1;
		if (v > 256) return 256;
		return int'(v);
	endfunction

	// offset, scale, texture size, then floor split and non-negative wrap
	function automatic void map_axis(longint pos, longint off, longint scl, int size,
			output int coord, output int frac);
		longint d, s, u, ip, r;
		d = pos - off;
		s = (d * scl) >>> 16;
		u = s * longint'(size);
		ip = u >>> 16;
		r = ip % longint'(size);
		if (r < 0) r += size;
		coord = int'(r);
		frac = int'(u & 64'hFFFF);
	endfunction

	function automatic logic [23:0] read_texel(int x, int y, int w);
		logic [23:0] t;
		t = texel_shadow[16'((y * w + x) % bwts_pkg::TexelDepth)];
		return paletted_reg ? palette_shadow[t[7:0]] : t;
	endfunction

	function automatic rgb88_t blend_sample(logic [31:0] px, logic [31:0] py);
		int w, h, x0, y0, x1, y1, fx, fy, sh;
		logic [23:0] p00, p01, p10, p11;
		longint lft, rgt, mix;
		logic [15:0] ch [3];
		rgb88_t res;
		w = clamp_size(width_reg);
		h = clamp_size(height_reg);
		map_axis(longint'($signed(px)), off_x, scl_x, w, x0, fx);
		map_axis(longint'($signed(py)), off_y, scl_y, h, y0, fy);
		x1 = (x0 + 1 == w) ? 0 : x0 + 1;
		y1 = (y0 + 1 == h) ? 0 : y0 + 1;
		p00 = read_texel(x0, y0, w);
		p01 = read_texel(x0, y1, w);
		p10 = read_texel(x1, y0, w);
		p11 = read_texel(x1, y1, w);
		for (int c = 0; c < 3; c++) begin
			sh = 16 - 8 * c;
			lft = longint'((p00 >> sh) & 8'hFF) * (65536 - fy)
				+ longint'((p01 >> sh) & 8'hFF) * fy;
			rgt = longint'((p10 >> sh) & 8'hFF) * (65536 - fy)
				+ longint'((p11 >> sh) & 8'hFF) * fy;
			mix = lft * (65536 - fx) + rgt * fx;
			ch[c] = mix[39:24];
		end
		res.red = ch[0];
		res.green = ch[1];
		res.blue = ch[2];
		return res;
	endfunction

	// track one accepted command in the predictor; red sits in the top byte of a texel
	function automatic void apply_command(bwts_pkg::cmd_t c, logic [111:0] d);
		case (c)
			bwts_pkg::CMD_WR_TEXEL: begin
				texel_shadow[d[15:0]] = paletted_reg ? {16'd0, d[23:16]}
					: {d[31:24], d[39:32], d[47:40]};
			end
			bwts_pkg::CMD_WR_PAL: begin
				palette_shadow[d[23:16]] = {d[31:24], d[39:32], d[47:40]};
			end
			bwts_pkg::CMD_SAMPLE: begin
				expected_rgb.push_back(blend_sample(d[79:48], d[111:80]));
			end
			default: ;
		endcase
	endfunction

	// ---------------- stimulus helpers ----------------
	// fields from the lowest bit up: address, index, red, green, blue, pos_x, pos_y
	function automatic logic [111:0] pack_item(logic [31:0] addr, logic [31:0] idx,
			logic [31:0] rgb, logic [31:0] px, logic [31:0] py);
		return {py, px, rgb[7:0], rgb[15:8], rgb[23:16], idx[7:0], addr[15:0]};
	endfunction

	task automatic send_item(bwts_pkg::cmd_t c, logic [111:0] d);
		int gap;
		if (random_gaps) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
		end
		s_tvalid <= 1'b1;
		s_tuser <= c;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		apply_command(c, d);
	endtask

	task automatic stop_sending();
		s_tvalid <= 1'b0;
		s_tuser <= bwts_pkg::CMD_NONE;
	endtask

	// sender pause until every expected result has come, plus pipeline depth
	task automatic drain();
		stop_sending();
		wait (expected_rgb.size() == 0);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(bwts_pkg::reg_idx_t r, logic [31:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (r)
			bwts_pkg::REG_TEX_WIDTH:  width_reg = v[8:0];
			bwts_pkg::REG_TEX_HEIGHT: height_reg = v[8:0];
			bwts_pkg::REG_PALETTED:   paletted_reg = v[0];
			bwts_pkg::REG_OFFSET_X:   off_x = longint'($signed(v));
			bwts_pkg::REG_OFFSET_Y:   off_y = longint'($signed(v));
			bwts_pkg::REG_SCALE_X:    scl_x = longint'($signed(v));
			bwts_pkg::REG_SCALE_Y:    scl_y = longint'($signed(v));
			default: ;
		endcase
	endtask

	task automatic sample_at(logic [31:0] px, logic [31:0] py);
		send_item(bwts_pkg::CMD_SAMPLE, pack_item($urandom, $urandom, $urandom, px, py));
	endtask

	function automatic logic [31:0] random_scale();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			3: return $urandom;
			default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
		endcase
	endfunction

	// ---------------- tests ----------------
	// texels 0..255 and every palette entry get written; all later sizes keep
	// width times height at most 256 so no sample reads undefined data
	task automatic test_fill_memories();
		for (int a = 0; a < 256; a++)
			send_item(bwts_pkg::CMD_WR_TEXEL,
				pack_item(a, $urandom, $urandom, $urandom, $urandom));
		for (int p = 0; p < bwts_pkg::PaletteDepth; p++)
			send_item(bwts_pkg::CMD_WR_PAL,
				pack_item($urandom, p, $urandom, $urandom, $urandom));
	endtask

	// position extremes on a 16 by 16 texture, texel corners and the unused command
	task automatic test_position_extremes();
		write_reg(bwts_pkg::REG_TEX_WIDTH, 32'd16);
		write_reg(bwts_pkg::REG_TEX_HEIGHT, 32'd16);
		sample_at(32'h0, 32'h0);
		sample_at(32'h7FFF_FFFF, 32'h8000_0000);
		sample_at(32'h8000_0000, 32'h7FFF_FFFF);
		sample_at(32'hFFFF_FFFF, 32'hFFFF_8000);
		sample_at(32'h00FF_FFFF, 32'h0000_8000);
		send_item(bwts_pkg::CMD_WR_TEXEL, pack_item('hFFFF, 'hFF, 'hFFFFFF, '1, '1));
		send_item(bwts_pkg::CMD_WR_TEXEL, pack_item(0, 0, 0, '0, '0));
		send_item(bwts_pkg::CMD_NONE,
			pack_item($urandom, $urandom, $urandom, $urandom, $urandom));
		sample_at(32'h00FF_C000, 32'h00FF_C000);
	endtask

	// a width of zero acts as one, width and height above 256 act as 256; extreme scales
	task automatic test_size_clamp();
		write_reg(bwts_pkg::REG_TEX_WIDTH, 32'd0);
		write_reg(bwts_pkg::REG_TEX_HEIGHT, 32'd511);
		sample_at($urandom, $urandom);
		sample_at(32'hFFFF_0000, 32'h0001_8000);
		write_reg(bwts_pkg::REG_TEX_WIDTH, 32'd257);
		write_reg(bwts_pkg::REG_TEX_HEIGHT, 32'd1);
		write_reg(bwts_pkg::REG_SCALE_X, 32'h8000_0000);
		write_reg(bwts_pkg::REG_SCALE_Y, 32'h7FFF_FFFF);
		write_reg(bwts_pkg::REG_OFFSET_X, 32'h7FFF_FFFF);
		write_reg(bwts_pkg::REG_OFFSET_Y, 32'h8000_0000);
		sample_at(32'h8000_0000, 32'h7FFF_FFFF);
		sample_at(32'h7FFF_FFFF, 32'h8000_0000);
	endtask

	// paletted texel writes store the index; reads go through the palette
	task automatic test_paletted();
		write_reg(bwts_pkg::REG_OFFSET_X, 32'h0);
		write_reg(bwts_pkg::REG_OFFSET_Y, 32'h0);
		write_reg(bwts_pkg::REG_SCALE_X, 32'h0001_0000);
		write_reg(bwts_pkg::REG_SCALE_Y, 32'h0001_0000);
		write_reg(bwts_pkg::REG_TEX_WIDTH, 32'd4);
		write_reg(bwts_pkg::REG_TEX_HEIGHT, 32'd3);
		write_reg(bwts_pkg::REG_PALETTED, 32'd1);
		send_item(bwts_pkg::CMD_WR_TEXEL, pack_item(5, 'hA5, 'h123456, '0, '0));
		send_item(bwts_pkg::CMD_WR_PAL, pack_item(0, 'hA5, 'hFF00FF, '0, '0));
		sample_at(32'h0000_4000, 32'h0000_C000);
		sample_at(32'hFFFF_C000, 32'hFFFF_4000);
		send_item(bwts_pkg::CMD_WR_PAL, pack_item(0, 'hA5, 'h00FF00, '0, '0));
		sample_at(32'h0001_0000, 32'h0001_0000);
	endtask

	// long receiver hold so the pipeline fills and stalls its input
	task automatic test_backpressure();
		hold_request = 400;
		for (int i = 0; i < 40; i++)
			sample_at($urandom, $urandom);
		drain();
	endtask

	// random phases of settings, each with mostly samples and some writes;
	// sizes stay inside the written texels
	task automatic test_random(int items);
		int done = 0;
		int w_cfg, h_cfg;
		random_gaps = 1'b1;
		stall_mode = 1;
		while (done < items) begin
			case ($urandom_range(0, 3))
				0: w_cfg = $urandom_range(17, 511);
				1: w_cfg = 0;
				default: w_cfg = $urandom_range(1, 16);
			endcase
			if (clamp_size(9'(w_cfg)) > 16) begin
				h_cfg = $urandom_range(0, 1);
			end else if (clamp_size(9'(w_cfg)) == 1 && $urandom_range(0, 1) == 0) begin
				h_cfg = $urandom_range(0, 511);
			end else begin
				h_cfg = $urandom_range(0, 16);
			end
			write_reg(bwts_pkg::REG_TEX_WIDTH, w_cfg);
			write_reg(bwts_pkg::REG_TEX_HEIGHT, h_cfg);
			write_reg(bwts_pkg::REG_PALETTED, $urandom_range(0, 1));
			write_reg(bwts_pkg::REG_OFFSET_X,
				$urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h7FFFF));
			write_reg(bwts_pkg::REG_OFFSET_Y,
				$urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h7FFFF));
			write_reg(bwts_pkg::REG_SCALE_X, random_scale());
			write_reg(bwts_pkg::REG_SCALE_Y, random_scale());
			stall_mode = $urandom_range(0, 3) == 0 ? 0 : 1;
			for (int i = 0; i < 100 && done < items; i++) begin
				case ($urandom_range(0, 19))
					0, 1, 2: send_item(bwts_pkg::CMD_WR_TEXEL,
						pack_item($urandom, $urandom, $urandom, $urandom, $urandom));
					3, 4: send_item(bwts_pkg::CMD_WR_PAL,
						pack_item($urandom, $urandom, $urandom, $urandom, $urandom));
					5: send_item(bwts_pkg::CMD_NONE,
						pack_item($urandom, $urandom, $urandom, $urandom, $urandom));
					6, 7, 8: sample_at($urandom, $urandom);
					default: sample_at($urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
						$urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000);
				endcase
				done++;
			end
		end
		drain();
	endtask

	// ---------------- result checker and receiver ----------------
	always @(posedge clk) begin
		rgb88_t exp_v;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_rgb.size() == 0) begin
				$error("result transfer with no sample outstanding: %h", m_tdata);
				mismatches++;
			end else begin
				exp_v = expected_rgb.pop_front();
				if (m_tdata[15:0] !== exp_v.red) begin
					$error("red_out expected %h actual %h", exp_v.red, m_tdata[15:0]);
					mismatches++;
				end
				if (m_tdata[31:16] !== exp_v.green) begin
					$error("green_out expected %h actual %h", exp_v.green, m_tdata[31:16]);
					mismatches++;
				end
				if (m_tdata[47:32] !== exp_v.blue) begin
					$error("blue_out expected %h actual %h", exp_v.blue, m_tdata[47:32]);
					mismatches++;
				end
			end
		end
		// hold-off counted here; otherwise a stall pattern with calm stretches
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (stall_mode == 0) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 9) < 7);
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		width_reg = 9'd256;
		height_reg = 9'd256;
		paletted_reg = 1'b0;
		off_x = 0;
		off_y = 0;
		scl_x = 65536;
		scl_y = 65536;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_memories();
		test_position_extremes();
		test_size_clamp();
		test_paletted();
		test_backpressure();
		test_random(480);
		drain();
		if (mismatches == 0 && expected_rgb.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/bwts_pkg.sv
sv/bwts_ram.sv
sv/bwts_coord.sv
sv/bwts_lerp.sv
sv/bilinear_wrap_texture_sampler.sv
sv/bwts_checker.sv
tb/tb_top.sv
